FILE: rtl/ds_pkg.sv
// ds_pkg: shared widths, codes and control/status structs for the dedup stack.
// Used by ds_ctrl, ds_datapath and dedup_stack; no dependencies.
`timescale 1ns / 1ps
package ds_pkg;

  localparam int VALUE_W  = 32;
  localparam int COUNT_W  = 7;
  localparam int STATUS_W = 2;

  localparam int DEF_STACK_DEPTH = 64;
  localparam int DEF_ITEM_WIDTH  = 32;

  localparam logic CMD_PUSH = 1'b0;
  localparam logic CMD_POP  = 1'b1;

  localparam logic [STATUS_W-1:0] ST_DONE  = 2'd0;
  localparam logic [STATUS_W-1:0] ST_DUP   = 2'd1;
  localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd2;
  localparam logic [STATUS_W-1:0] ST_FULL  = 2'd3;

  typedef struct packed {
    logic                load;
    logic                scan_rd;
    logic                pop_rd;
    logic                push_wr;
    logic                finish;
    logic                pop_out;
    logic [STATUS_W-1:0] status;
  } ds_cmd_t;

  typedef struct packed {
    logic cnt_zero;
    logic cnt_full;
    logic hit;
    logic scan_end;
  } ds_stat_t;

endpackage

FILE: rtl/ds_ctrl.sv
// ds_ctrl: sequencer for the dedup stack (accept, duplicate scan, pop read).
// Depends on ds_pkg for command/status structs and codes.
`timescale 1ns / 1ps
module ds_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  input  logic              in_cmd,
  input  ds_pkg::ds_stat_t  stat,
  output ds_pkg::ds_cmd_t   cmd,
  output logic              busy
);
  import ds_pkg::*;

  localparam logic [1:0] S_IDLE     = 2'd0;
  localparam logic [1:0] S_SCAN     = 2'd1;
  localparam logic [1:0] S_POP      = 2'd2;
  localparam logic [1:0] S_POP_WAIT = 2'd3;

  logic [1:0] state_r;
  logic [1:0] state_nxt;

  assign busy = (state_r != S_IDLE);

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    cmd.status = ST_DONE;
    case (state_r)
      S_IDLE: begin
        if (start) begin
          cmd.load  = 1'b1;
          state_nxt = (in_cmd == CMD_PUSH) ? S_SCAN : S_POP;
        end
      end
      S_SCAN: begin
        if (stat.hit) begin
          cmd.finish = 1'b1;
          cmd.status = ST_DUP;
          state_nxt  = S_IDLE;
        end else if (stat.scan_end) begin
          cmd.finish = 1'b1;
          if (stat.cnt_full) begin
            cmd.status = ST_FULL;
          end else begin
            cmd.push_wr = 1'b1;
            cmd.status  = ST_DONE;
          end
          state_nxt = S_IDLE;
        end else begin
          cmd.scan_rd = 1'b1;
        end
      end
      S_POP: begin
        if (stat.cnt_zero) begin
          cmd.finish = 1'b1;
          cmd.status = ST_EMPTY;
          state_nxt  = S_IDLE;
        end else begin
          cmd.pop_rd = 1'b1;
          state_nxt  = S_POP_WAIT;
        end
      end
      S_POP_WAIT: begin
        cmd.finish  = 1'b1;
        cmd.pop_out = 1'b1;
        cmd.status  = ST_DONE;
        state_nxt   = S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

`ifndef SYNTHESIS
  a_idle_after_finish: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.finish |=> !busy)
    else $error("controller not idle after finish");
  a_wait_follows_pop: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.pop_rd |=> (state_r == S_POP_WAIT))
    else $error("pop read not followed by wait");
  a_no_write_on_hit: assert property (@(posedge clk) disable iff (!rst_n)
    stat.hit && (state_r == S_SCAN) |-> !cmd.push_wr)
    else $error("write issued on duplicate");
`endif

endmodule

FILE: rtl/ds_datapath.sv
// ds_datapath: entry memory, entry count, scan index and result registers.
// Depends on ds_pkg; driven by ds_ctrl commands.
`timescale 1ns / 1ps
module ds_datapath #(
  parameter int STACK_DEPTH = ds_pkg::DEF_STACK_DEPTH,
  parameter int ITEM_WIDTH  = ds_pkg::DEF_ITEM_WIDTH
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic [ds_pkg::VALUE_W-1:0]    in_value,
  input  ds_pkg::ds_cmd_t               cmd,
  output ds_pkg::ds_stat_t              stat,
  output logic                          out_valid,
  output logic                          out_ok,
  output logic [ds_pkg::STATUS_W-1:0]   out_status,
  output logic [ds_pkg::VALUE_W-1:0]    out_popped_value,
  output logic [ds_pkg::COUNT_W-1:0]    out_count
);
  import ds_pkg::*;

  localparam int AW = $clog2(STACK_DEPTH);
  localparam int CW = $clog2(STACK_DEPTH + 1);
  localparam int XW = ITEM_WIDTH + VALUE_W;

  logic [ITEM_WIDTH-1:0] mem [STACK_DEPTH];

  logic [ITEM_WIDTH-1:0] item_r, item_nxt;
  logic [ITEM_WIDTH-1:0] rd_r;
  logic [CW-1:0]         count_r, count_nxt;
  logic [CW-1:0]         idx_r, idx_nxt;
  logic                  last_r, last_nxt;
  logic                  rdv_r, rdv_nxt;
  logic [AW-1:0]         raddr;
  logic [CW-1:0]         cnt_dec;
  logic [XW-1:0]         in_ext;
  logic [XW-1:0]         rd_ext;
  logic                  rd_en;

  logic                  out_valid_r;
  logic                  out_ok_r;
  logic [STATUS_W-1:0]   out_status_r;
  logic [VALUE_W-1:0]    out_popped_r;
  logic [COUNT_W-1:0]    out_count_r;
  logic [CW+COUNT_W-1:0] cnt_ext;

  assign in_ext  = {{ITEM_WIDTH{1'b0}}, in_value};
  assign rd_ext  = {{VALUE_W{1'b0}}, rd_r};
  assign cnt_dec = count_r - CW'(1);
  assign raddr   = cmd.pop_rd ? cnt_dec[AW-1:0] : idx_r[AW-1:0];
  assign rd_en   = cmd.pop_rd | cmd.scan_rd;
  assign cnt_ext = {{COUNT_W{1'b0}}, count_nxt};

  assign stat.cnt_zero = (count_r == '0);
  assign stat.cnt_full = (count_r == CW'(STACK_DEPTH));
  assign stat.hit      = rdv_r && (rd_r == item_r);
  assign stat.scan_end = (count_r == '0) || (rdv_r && last_r);

  always_comb begin
    item_nxt  = cmd.load ? in_ext[ITEM_WIDTH-1:0] : item_r;
    idx_nxt   = idx_r;
    last_nxt  = last_r;
    rdv_nxt   = rdv_r;
    count_nxt = count_r;
    if (cmd.load) begin
      idx_nxt = '0;
      rdv_nxt = 1'b0;
    end
    if (cmd.scan_rd) begin
      idx_nxt  = idx_r + CW'(1);
      last_nxt = ((idx_r + CW'(1)) == count_r);
      rdv_nxt  = 1'b1;
    end
    if (cmd.pop_rd) begin
      count_nxt = cnt_dec;
    end else if (cmd.push_wr) begin
      count_nxt = count_r + CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.push_wr) begin
      mem[count_r[AW-1:0]] <= item_r;
    end
    if (rd_en) begin
      rd_r <= mem[raddr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      rdv_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      count_r     <= count_nxt;
      rdv_r       <= rdv_nxt;
      out_valid_r <= cmd.finish;
    end
  end

  always_ff @(posedge clk) begin
    item_r <= item_nxt;
    idx_r  <= idx_nxt;
    last_r <= last_nxt;
    if (cmd.finish) begin
      out_ok_r     <= (cmd.status == ST_DONE) || (cmd.status == ST_DUP);
      out_status_r <= cmd.status;
      out_popped_r <= cmd.pop_out ? rd_ext[VALUE_W-1:0] : '0;
      out_count_r  <= cnt_ext[COUNT_W-1:0];
    end
  end

  assign out_valid        = out_valid_r;
  assign out_ok           = out_ok_r;
  assign out_status       = out_status_r;
  assign out_popped_value = out_popped_r;
  assign out_count        = out_count_r;

`ifndef SYNTHESIS
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CW'(STACK_DEPTH))
    else $error("entry count above depth");
  a_no_write_full: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.push_wr |-> !stat.cnt_full)
    else $error("write into full stack");
  a_pop_dec: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.pop_rd |=> (count_r == $past(count_r) - CW'(1)))
    else $error("pop did not decrement count");
  a_fail_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !out_ok_r |-> (out_status_r == ST_EMPTY) || (out_status_r == ST_FULL))
    else $error("failure with wrong status");
`endif

endmodule

FILE: rtl/dedup_stack.sv
// dedup_stack: LIFO stack without duplicates; a push scans held entries one per cycle
// through the single memory read port, until a hit or until every held entry is compared.
// busy drops in the strobe cycle, so a new item starts only once the last one's result is out.
// Results cannot be stalled. Synchronous active-low reset empties the stack at once.
// Depends on ds_pkg, ds_ctrl and ds_datapath.
`timescale 1ns / 1ps
module dedup_stack #(
  parameter int STACK_DEPTH = ds_pkg::DEF_STACK_DEPTH,
  parameter int ITEM_WIDTH  = ds_pkg::DEF_ITEM_WIDTH
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  output logic                          busy,
  input  logic                          in_cmd,
  input  logic [ds_pkg::VALUE_W-1:0]    in_value,
  output logic                          out_valid,
  output logic                          out_ok,
  output logic [ds_pkg::STATUS_W-1:0]   out_status,
  output logic [ds_pkg::VALUE_W-1:0]    out_popped_value,
  output logic [ds_pkg::COUNT_W-1:0]    out_count
);
  import ds_pkg::*;

  ds_cmd_t  cmd;
  ds_stat_t stat;

  ds_ctrl u_ctrl (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (start),
    .in_cmd (in_cmd),
    .stat   (stat),
    .cmd    (cmd),
    .busy   (busy)
  );

  ds_datapath #(
    .STACK_DEPTH (STACK_DEPTH),
    .ITEM_WIDTH  (ITEM_WIDTH)
  ) u_dp (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_value         (in_value),
    .cmd              (cmd),
    .stat             (stat),
    .out_valid        (out_valid),
    .out_ok           (out_ok),
    .out_status       (out_status),
    .out_popped_value (out_popped_value),
    .out_count        (out_count)
  );

endmodule
